// ===== design/wspl_pkg.sv =====
// Shared types, widths and constants for the wheel speed PID/PWM loop.
package wspl_pkg;

    localparam int AVG_WINDOW_DEF = 10;
    localparam int DUTY_MAX_DEF   = 1023;

    localparam int TICKS_W  = 12;
    localparam int TARGET_W = 13;
    localparam int SPEED_W  = 14;
    localparam int DUTY_W   = 10;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 16;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int INTEG_W  = 32;
    localparam int FRAC_W   = 12;
    localparam int ACC_W    = 50;

    localparam int SPEED_MAX = 16383;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;

    localparam logic [CFG_W-1:0] RPM_SCALE_RST = 16'd654;
    localparam logic [CFG_W-1:0] GAIN_P_RST    = 16'd410;
    localparam logic [CFG_W-1:0] GAIN_I_RST    = 16'd0;
    localparam logic [CFG_W-1:0] GAIN_D_RST    = 16'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RPM,
        ST_SUM,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_ACC,
        ST_DUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic   load;
        state_t state;
        logic   wrapped;
    } lane_ctrl_t;

endpackage

// ===== design/wspl_lane.sv =====
// One wheel lane: tick scaling, averaging window, PID step and duty update.
module wspl_lane #(
    parameter int AVG_WINDOW = wspl_pkg::AVG_WINDOW_DEF,
    parameter int DUTY_MAX   = wspl_pkg::DUTY_MAX_DEF,
    localparam int SLOT_W    = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1,
    localparam int HOLD_W    = $clog2(DUTY_MAX + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wspl_pkg::lane_ctrl_t                 ctrl,
    input  logic [SLOT_W-1:0]                    slot,
    input  logic [wspl_pkg::TICKS_W-1:0]         ticks,
    input  logic signed [wspl_pkg::TARGET_W-1:0] target,
    input  logic [wspl_pkg::CFG_W-1:0]           rpm_scale,
    input  logic signed [wspl_pkg::GAIN_W-1:0]   gain_p,
    input  logic signed [wspl_pkg::GAIN_W-1:0]   gain_i,
    input  logic signed [wspl_pkg::GAIN_W-1:0]   gain_d,
    output logic [wspl_pkg::SPEED_W-1:0]         speed,
    output logic [HOLD_W-1:0]                    duty
);
    import wspl_pkg::*;

    localparam int SUM_W   = $clog2(AVG_WINDOW * SPEED_MAX + 1);
    localparam int DIV_SH  = SUM_W + $clog2(AVG_WINDOW);
    localparam int RECIP_W = SUM_W + 2;
    localparam longint unsigned RECIP = (longint'(1) << DIV_SH) / AVG_WINDOW + 1;
    localparam int QUOT_W  = SUM_W + RECIP_W;
    localparam int RPM_P_W = TICKS_W + CFG_W;
    localparam int WHOLE_W = ACC_W - FRAC_W;

    logic [TICKS_W-1:0]         ticks_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic [SPEED_W-1:0]         rpm_reg;
    logic [SPEED_W-1:0]         mem_q_reg;
    logic [SPEED_W-1:0]         window_mem [AVG_WINDOW];
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [QUOT_W-1:0]          quot_reg;
    logic [QUOT_W-1:0]          quot_next;
    logic [SPEED_W-1:0]         speed_reg;
    logic [SPEED_W-1:0]         speed_next;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    prev_reg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [2*GAIN_W-1:0] p_reg;
    logic signed [2*GAIN_W-1:0] p_next;
    logic signed [GAIN_W+INTEG_W-1:0] i_reg;
    logic signed [GAIN_W+INTEG_W-1:0] i_next;
    logic signed [GAIN_W+DIFF_W-1:0]  d_reg;
    logic signed [GAIN_W+DIFF_W-1:0]  d_next;
    logic signed [ACC_W-1:0]    total_reg;
    logic signed [ACC_W-1:0]    total_next;
    logic [WHOLE_W-1:0]         whole;
    logic [HOLD_W-1:0]          duty_reg;
    logic [HOLD_W-1:0]          duty_next;
    logic [RPM_P_W-1:0]         rpm_prod;
    logic [RPM_P_W-9:0]         rpm_shift;
    logic [SPEED_W-1:0]         rpm_next;
    logic [SPEED_W-1:0]         old_rpm;

    always_comb
    begin
        rpm_prod  = RPM_P_W'(ticks_reg) * RPM_P_W'(rpm_scale);
        rpm_shift = rpm_prod[RPM_P_W-1:8];
        rpm_next  = (rpm_shift > (RPM_P_W-8)'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                         : rpm_shift[SPEED_W-1:0];

        // Slots not yet written since reset read as zero
        old_rpm  = ctrl.wrapped ? mem_q_reg : '0;
        sum_next = sum_reg - SUM_W'(old_rpm) + SUM_W'(rpm_reg);

        // Exact division by the window length: multiply by a rounded-up reciprocal
        quot_next  = QUOT_W'(sum_reg) * QUOT_W'(RECIP);
        speed_next = quot_reg[DIV_SH +: SPEED_W];
        err_next   = ERR_W'(target_reg) - $signed({2'b00, speed_next});

        diff   = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        p_next = gain_p * err_reg;
        i_next = gain_i * integ_reg;
        d_next = gain_d * diff;

        total_next = ACC_W'($signed({1'b0, duty_reg, {FRAC_W{1'b0}}}))
                   + ACC_W'(p_reg) + ACC_W'(i_reg) + ACC_W'(d_reg);

        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            // Saturate at the signed limits
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        whole = total_reg[ACC_W-1:FRAC_W];
        if (total_reg[ACC_W-1] || (whole == '0))
        begin
            duty_next = '0;
        end
        else if (whole > WHOLE_W'(DUTY_MAX))
        begin
            duty_next = HOLD_W'(DUTY_MAX);
        end
        else
        begin
            duty_next = whole[HOLD_W-1:0];
        end
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            integ_reg <= '0;
            prev_reg  <= '0;
            duty_reg  <= '0;
        end
        else
        begin
            case (ctrl.state)
                ST_SUM:
                begin
                    sum_reg <= sum_next;
                end
                ST_ACC:
                begin
                    integ_reg <= integ_next;
                    prev_reg  <= err_reg;
                end
                ST_DUTY:
                begin
                    duty_reg <= duty_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working values of the current item
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ticks_reg  <= ticks;
            target_reg <= target;
        end
        case (ctrl.state)
            ST_RPM:
            begin
                rpm_reg <= rpm_next;
            end
            ST_DIV:
            begin
                quot_reg <= quot_next;
            end
            ST_ERR:
            begin
                speed_reg <= speed_next;
                err_reg   <= err_next;
            end
            ST_MUL:
            begin
                p_reg <= p_next;
                i_reg <= i_next;
                d_reg <= d_next;
            end
            ST_ACC:
            begin
                total_reg <= total_next;
            end
            default:
            begin
            end
        endcase
    end

    // Averaging window store
    always_ff @(posedge clk)
    begin
        if (ctrl.state == ST_RPM)
        begin
            mem_q_reg <= window_mem[slot];
        end
        if (ctrl.state == ST_SUM)
        begin
            window_mem[slot] <= rpm_reg;
        end
    end

    assign speed = speed_reg;
    assign duty  = duty_reg;

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctrl.state) == ST_DUTY) |-> (int'(duty_reg) <= DUTY_MAX))
        else $error("duty above its limit");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.state == ST_DIV) |-> (int'(sum_reg) <= AVG_WINDOW * SPEED_MAX))
        else $error("window sum out of range");

    a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.state != ST_ACC) |=> $stable(integ_reg))
        else $error("integral changed outside its update step");

endmodule

// ===== design/wheel_speed_pid_pwm_loop.sv =====
// Top level of the two-wheel speed loop: config registers, sequencer, lanes, result register.
//
// Usage: one input transfer per control tick carries both wheels' encoder tick counts and
// target speeds. Each wheel runs in its own lane; a result transfer then carries both new
// PWM duty values and both window-averaged speeds.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 rpm scale, 1..3 PID
// gains) on the clock edge; indexes above 3 are ignored. Write only while the loop is idle.
// Sequence: after the input transfer the sequencer runs 8 steps, one each for scaling,
// window update, division, error, the three gain products, accumulation, duty clamp and
// result load.
// The next transfer is taken only in the idle state, after the last item's result load;
// in_stall is high while a lane sequence is running.
// A finished result sits in the output register and a new input is taken meanwhile; if the
// receiver still stalls when the next result is ready, the sequencer waits at the load step.
// Reset: config registers return to their defaults, the averaging windows read as zero,
// integrals, previous errors and held duty values are cleared, and no result is pending.
module wheel_speed_pid_pwm_loop #(
    parameter int AVG_WINDOW = wspl_pkg::AVG_WINDOW_DEF,
    parameter int DUTY_MAX   = wspl_pkg::DUTY_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wspl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wspl_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wspl_pkg::TICKS_W-1:0]         left_ticks,
    input  logic [wspl_pkg::TICKS_W-1:0]         right_ticks,
    input  logic signed [wspl_pkg::TARGET_W-1:0] target_left_rpm,
    input  logic signed [wspl_pkg::TARGET_W-1:0] target_right_rpm,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wspl_pkg::DUTY_W-1:0]          left_duty,
    output logic [wspl_pkg::DUTY_W-1:0]          right_duty,
    output logic [wspl_pkg::SPEED_W-1:0]         left_speed,
    output logic [wspl_pkg::SPEED_W-1:0]         right_speed
);
    import wspl_pkg::*;

    localparam int SLOT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int HOLD_W = $clog2(DUTY_MAX + 1);

    logic [CFG_W-1:0]         rpm_scale_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic                wrapped_reg;
    lane_ctrl_t          ctrl;
    logic                in_xfer;
    logic                out_load;

    logic                out_valid_reg;
    logic [DUTY_W-1:0]   left_duty_reg;
    logic [DUTY_W-1:0]   right_duty_reg;
    logic [SPEED_W-1:0]  left_speed_reg;
    logic [SPEED_W-1:0]  right_speed_reg;

    logic [SPEED_W-1:0]  lane_speed_l;
    logic [SPEED_W-1:0]  lane_speed_r;
    logic [HOLD_W-1:0]   lane_duty_l;
    logic [HOLD_W-1:0]   lane_duty_r;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_scale_reg <= RPM_SCALE_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RPM_SCALE: rpm_scale_reg <= cfg_data;
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_RPM;
            ST_RPM:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_DUTY;
            ST_DUTY: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Window slot pointer; once it has wrapped every slot holds a written value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (state_reg == ST_SUM)
        begin
            if (int'(slot_reg) == AVG_WINDOW - 1)
            begin
                slot_reg    <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    assign ctrl.load    = in_xfer;
    assign ctrl.state   = state_reg;
    assign ctrl.wrapped = wrapped_reg;

    wspl_lane #(
        .AVG_WINDOW (AVG_WINDOW),
        .DUTY_MAX   (DUTY_MAX)
    ) u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .slot      (slot_reg),
        .ticks     (left_ticks),
        .target    (target_left_rpm),
        .rpm_scale (rpm_scale_reg),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .speed     (lane_speed_l),
        .duty      (lane_duty_l)
    );

    wspl_lane #(
        .AVG_WINDOW (AVG_WINDOW),
        .DUTY_MAX   (DUTY_MAX)
    ) u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .slot      (slot_reg),
        .ticks     (right_ticks),
        .target    (target_right_rpm),
        .rpm_scale (rpm_scale_reg),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .speed     (lane_speed_r),
        .duty      (lane_duty_r)
    );

    // Result register: merge both lanes into one transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_duty_reg   <= DUTY_W'(lane_duty_l);
            right_duty_reg  <= DUTY_W'(lane_duty_r);
            left_speed_reg  <= lane_speed_l;
            right_speed_reg <= lane_speed_r;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_duty   = left_duty_reg;
    assign right_duty  = right_duty_reg;
    assign left_speed  = left_speed_reg;
    assign right_speed = right_speed_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result presented without a finished sequence");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RPM))
        else $error("accepted item did not start the lane sequence");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(slot_reg) < AVG_WINDOW)
        else $error("window slot out of range");

    a_wait_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_valid_reg && out_stall) |=> (state_reg == ST_OUT))
        else $error("result overwritten while the receiver stalls");

endmodule
